// File: hw/rtl/pse_pkg.sv
// Shared types and constants for the polyline strip extruder.
package pse_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int ITER_STEPS     = 32;
  localparam int ITER_CNT_W     = $clog2(ITER_STEPS + 1);

  localparam logic [30:0] STRIP_WIDTH_RESET = 31'd65536;

  // configuration register indexes
  localparam logic [0:0] REG_STRIP_WIDTH    = 1'b0;
  localparam logic [0:0] REG_SURFACE_HEIGHT = 1'b1;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIFF,
    S_SQA,
    S_SQB,
    S_CHK,
    S_SQRT,
    S_STORE,
    S_EM_START,
    S_RA,
    S_RB,
    S_RC,
    S_MULX,
    S_GOX,
    S_DIVX,
    S_MULZ,
    S_GOZ,
    S_DIVZ,
    S_GOU,
    S_DIVU,
    S_OUT0,
    S_OUT1,
    S_NEXT,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/polyline_strip_extruder.sv
// Polyline strip extruder: turns a centerline path into a triangle-strip vertex run.
// Points arrive one per request and are kept with their running arc length. A
// point takes two squarings in the shared 32x32 multiplier and a 32-step square
// root in the shared iterative unit, which is skipped when the squares of the
// segment overflow; the first point of a path is stored without a square root and
// a point past a full store is dropped. When the point marked last has been stored,
// every stored point yields two vertices (right side, then left side); each point
// takes three reads of the point memory, the square root and three 32-step divisions
// that run one after another through the same iterative unit. The tangent is halved
// and squared again when its squares overflow, a zero tangent skips two divisions
// and a zero total length skips the third, and a vertex waits while the output is
// stalled. A path with fewer than two points yields nothing. Points beyond
// MAX_POINTS are dropped and flagged on every vertex of that path.
module polyline_strip_extruder #(
  parameter int MAX_POINTS = pse_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // point input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic               last_point,
  // vertex output
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] vert_x,
  output logic signed [31:0] vert_y,
  output logic signed [31:0] vert_z,
  output logic [16:0]        u_coord,
  output logic               side,
  output logic               dropped_points,
  output logic               last_vertex,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  pse_pkg::state_t state, state_next;

  // configuration
  logic [30:0]        strip_width;
  logic signed [31:0] surface_height;

  // path state
  logic [CW-1:0] point_count;
  logic [31:0]   total_length;
  logic          overflow_flag;
  logic          emitting;
  logic          last_r;
  logic [AW-1:0] idx;

  // working registers
  logic signed [31:0] cur_x, cur_y, prev_x, prev_y, pa_x, pa_y, pb_x, pb_y;
  logic [31:0]        cur_arc, prev_arc;
  logic [31:0]        mag_a, mag_b;
  logic               dx_neg, dy_pos;
  logic [63:0]        sq;
  logic [64:0]        sumsq;
  logic [63:0]        prod_r;
  logic [31:0]        len;
  logic [31:0]        ox, oz;
  logic [16:0]        u_val;

  // memory
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [95:0]   ram_rdata;

  // shared units
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          prod;
  pse_pkg::iter_req_t   iter_req;
  pse_pkg::iter_stat_t  iter_stat;
  logic [63:0]          iter_num;
  logic [32:0]          iter_den;
  logic [31:0]          iter_res;

  // decode helpers
  logic          in_acc, out_free, out_load, idx_last, full;
  logic [AW-1:0] idx_a, idx_b;
  logic signed [32:0] dx, dy;
  logic [32:0]   arc_sum;
  logic [31:0]   arc_new;
  logic signed [31:0] vx, vz;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign idx_last = ((CW'(idx) + CW'(1)) == point_count);
  assign full     = (point_count == CW'(MAX_POINTS));
  assign idx_a    = (idx == '0) ? '0 : idx - 1'b1;
  assign idx_b    = idx_last ? idx : idx + 1'b1;
  assign cfg_ready = 1'b1;

  pse_ram #(
    .WIDTH(96),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(point_count[AW-1:0]),
    .wdata({cur_x, cur_y, arc_new}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pse_iter u_iter (
    .clk   (clk),
    .rst   (rst),
    .req   (iter_req),
    .num   (iter_num),
    .den   (iter_den),
    .stat  (iter_stat),
    .result(iter_res)
  );

  assign prod = mul_a * mul_b;

  // tangent components
  always_comb begin
    if (emitting) begin
      dx = {pb_x[31], pb_x} - {pa_x[31], pa_x};
      dy = {pb_y[31], pb_y} - {pa_y[31], pa_y};
    end else begin
      dx = {cur_x[31], cur_x} - {prev_x[31], prev_x};
      dy = {cur_y[31], cur_y} - {prev_y[31], prev_y};
    end
  end

  // saturating running arc length
  assign arc_sum = {1'b0, prev_arc} + {1'b0, len};
  always_comb begin
    if (point_count == '0) begin
      arc_new = '0;
    end else if (arc_sum[32]) begin
      arc_new = '1;
    end else begin
      arc_new = arc_sum[31:0];
    end
  end

  // vertex position for the side being loaded
  function automatic logic signed [31:0] sat_off(input logic signed [31:0] base,
                                                 input logic [31:0] off,
                                                 input logic neg);
    logic signed [33:0] s;
    s = neg ? ({{2{base[31]}}, base} - {2'b00, off}) : ({{2{base[31]}}, base} + {2'b00, off});
    if (s > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -34'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return s[31:0];
    end
  endfunction

  always_comb begin
    vx = sat_off(cur_x, ox, dy_pos ^ (state == pse_pkg::S_OUT1));
    vz = sat_off(cur_y, oz, dx_neg ^ (state == pse_pkg::S_OUT1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pse_pkg::S_IDLE: begin
        if (in_acc) begin
          if (full) begin
            state_next = last_point ? pse_pkg::S_EM_START : pse_pkg::S_IDLE;
          end else if (point_count == '0) begin
            state_next = pse_pkg::S_STORE;
          end else begin
            state_next = pse_pkg::S_DIFF;
          end
        end
      end
      pse_pkg::S_DIFF:  state_next = pse_pkg::S_SQA;
      pse_pkg::S_SQA:   state_next = pse_pkg::S_SQB;
      pse_pkg::S_SQB:   state_next = pse_pkg::S_CHK;
      pse_pkg::S_CHK: begin
        if (sumsq[64]) begin
          state_next = emitting ? pse_pkg::S_SQA : pse_pkg::S_STORE;
        end else begin
          state_next = pse_pkg::S_SQRT;
        end
      end
      pse_pkg::S_SQRT: begin
        if (iter_stat.done) begin
          if (!emitting) begin
            state_next = pse_pkg::S_STORE;
          end else if (iter_res == '0) begin
            state_next = pse_pkg::S_GOU;
          end else begin
            state_next = pse_pkg::S_MULX;
          end
        end
      end
      pse_pkg::S_STORE: state_next = last_r ? pse_pkg::S_EM_START : pse_pkg::S_IDLE;
      pse_pkg::S_EM_START: begin
        state_next = (point_count < CW'(2)) ? pse_pkg::S_DONE : pse_pkg::S_RA;
      end
      pse_pkg::S_RA:    state_next = pse_pkg::S_RB;
      pse_pkg::S_RB:    state_next = pse_pkg::S_RC;
      pse_pkg::S_RC:    state_next = pse_pkg::S_DIFF;
      pse_pkg::S_MULX:  state_next = pse_pkg::S_GOX;
      pse_pkg::S_GOX:   state_next = pse_pkg::S_DIVX;
      pse_pkg::S_DIVX:  state_next = iter_stat.done ? pse_pkg::S_MULZ : pse_pkg::S_DIVX;
      pse_pkg::S_MULZ:  state_next = pse_pkg::S_GOZ;
      pse_pkg::S_GOZ:   state_next = pse_pkg::S_DIVZ;
      pse_pkg::S_DIVZ:  state_next = iter_stat.done ? pse_pkg::S_GOU : pse_pkg::S_DIVZ;
      pse_pkg::S_GOU: begin
        state_next = (total_length == '0) ? pse_pkg::S_OUT0 : pse_pkg::S_DIVU;
      end
      pse_pkg::S_DIVU:  state_next = iter_stat.done ? pse_pkg::S_OUT0 : pse_pkg::S_DIVU;
      pse_pkg::S_OUT0:  state_next = out_free ? pse_pkg::S_OUT1 : pse_pkg::S_OUT0;
      pse_pkg::S_OUT1:  state_next = out_free ? pse_pkg::S_NEXT : pse_pkg::S_OUT1;
      pse_pkg::S_NEXT:  state_next = idx_last ? pse_pkg::S_DONE : pse_pkg::S_RA;
      pse_pkg::S_DONE:  state_next = pse_pkg::S_IDLE;
      default:          state_next = pse_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = (state == pse_pkg::S_IDLE);
    ram_we       = (state == pse_pkg::S_STORE);
    ram_raddr    = idx;
    mul_a        = mag_a;
    mul_b        = mag_a;
    iter_req     = '{start: 1'b0, op: pse_pkg::OP_DIV};
    iter_num     = {prod_r + {32'd0, len}};
    iter_den     = {len, 1'b0};
    out_load     = 1'b0;
    case (state)
      pse_pkg::S_RA:   ram_raddr = idx_a;
      pse_pkg::S_RB:   ram_raddr = idx_b;
      pse_pkg::S_SQB: begin
        mul_a = mag_b;
        mul_b = mag_b;
      end
      pse_pkg::S_CHK: begin
        iter_req = '{start: !sumsq[64], op: pse_pkg::OP_SQRT};
        iter_num = sumsq[63:0];
      end
      pse_pkg::S_MULX: begin
        mul_a = mag_b;
        mul_b = {1'b0, strip_width};
      end
      pse_pkg::S_MULZ: begin
        mul_a = mag_a;
        mul_b = {1'b0, strip_width};
      end
      pse_pkg::S_GOX:  iter_req = '{start: 1'b1, op: pse_pkg::OP_DIV};
      pse_pkg::S_GOZ:  iter_req = '{start: 1'b1, op: pse_pkg::OP_DIV};
      pse_pkg::S_GOU: begin
        iter_req = '{start: (total_length != '0), op: pse_pkg::OP_DIV};
        iter_num = {16'd0, cur_arc, 16'd0};
        iter_den = {1'b0, total_length};
      end
      pse_pkg::S_OUT0: out_load = out_free;
      pse_pkg::S_OUT1: out_load = out_free;
      default: begin
      end
    endcase
  end

  // state register and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pse_pkg::S_IDLE;
      point_count    <= '0;
      total_length   <= '0;
      overflow_flag  <= 1'b0;
      emitting       <= 1'b0;
      out_valid      <= 1'b0;
      strip_width    <= pse_pkg::STRIP_WIDTH_RESET;
      surface_height <= '0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && !out_ready) || out_load;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pse_pkg::REG_STRIP_WIDTH:    strip_width    <= cfg_data[30:0];
          pse_pkg::REG_SURFACE_HEIGHT: surface_height <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == pse_pkg::S_IDLE && in_acc && full) begin
        overflow_flag <= 1'b1;
      end
      if (state == pse_pkg::S_STORE) begin
        point_count  <= point_count + 1'b1;
        total_length <= arc_new;
      end
      if (state == pse_pkg::S_EM_START) begin
        emitting <= 1'b1;
      end
      if (state == pse_pkg::S_DONE) begin
        point_count   <= '0;
        total_length  <= '0;
        overflow_flag <= 1'b0;
        emitting      <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      pse_pkg::S_IDLE: begin
        if (in_acc) begin
          cur_x  <= point_x;
          cur_y  <= point_y;
          last_r <= last_point;
          len    <= '0;
        end
      end
      pse_pkg::S_DIFF: begin
        if (emitting) begin
          cur_x   <= ram_rdata[95:64];
          cur_y   <= ram_rdata[63:32];
          cur_arc <= ram_rdata[31:0];
        end
        mag_a  <= dx[32] ? 32'(-dx) : dx[31:0];
        mag_b  <= dy[32] ? 32'(-dy) : dy[31:0];
        dx_neg <= dx[32];
        dy_pos <= !dy[32] && (dy != '0);
      end
      pse_pkg::S_SQA: sq <= prod;
      pse_pkg::S_SQB: sumsq <= {1'b0, sq} + {1'b0, prod};
      pse_pkg::S_CHK: begin
        if (sumsq[64]) begin
          mag_a <= {1'b0, mag_a[31:1]};
          mag_b <= {1'b0, mag_b[31:1]};
          len   <= '1;
        end
      end
      pse_pkg::S_SQRT: begin
        if (iter_stat.done) begin
          len <= iter_res;
          ox  <= '0;
          oz  <= '0;
        end
      end
      pse_pkg::S_STORE: begin
        prev_x   <= cur_x;
        prev_y   <= cur_y;
        prev_arc <= arc_new;
      end
      pse_pkg::S_EM_START: idx <= '0;
      pse_pkg::S_RB: begin
        pa_x <= ram_rdata[95:64];
        pa_y <= ram_rdata[63:32];
      end
      pse_pkg::S_RC: begin
        pb_x <= ram_rdata[95:64];
        pb_y <= ram_rdata[63:32];
      end
      pse_pkg::S_MULX: prod_r <= prod;
      pse_pkg::S_MULZ: prod_r <= prod;
      pse_pkg::S_DIVX: if (iter_stat.done) ox <= iter_res;
      pse_pkg::S_DIVZ: if (iter_stat.done) oz <= iter_res;
      pse_pkg::S_GOU:  u_val <= '0;
      pse_pkg::S_DIVU: if (iter_stat.done) u_val <= iter_res[16:0];
      pse_pkg::S_NEXT: if (!idx_last) idx <= idx + 1'b1;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      vert_x         <= vx;
      vert_y         <= surface_height;
      vert_z         <= vz;
      u_coord        <= u_val;
      side           <= (state == pse_pkg::S_OUT1);
      dropped_points <= overflow_flag;
      last_vertex    <= (state == pse_pkg::S_OUT1) && idx_last;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_iter_done: assert property (@(posedge clk) disable iff (rst)
    iter_stat.done |-> $past(iter_stat.busy))
    else $error("iterative unit done without running");

  a_path_clear: assert property (@(posedge clk) disable iff (rst)
    state == pse_pkg::S_DONE |=> point_count == '0 && total_length == '0 && !overflow_flag)
    else $error("path state not cleared at path end");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("vertex loaded over a pending one");
`endif

endmodule

// File: hw/rtl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pse_iter.sv
// Iterative square root / long division unit sharing one compare-subtract stage.
module pse_iter (
  input  logic               clk,
  input  logic               rst,
  input  pse_pkg::iter_req_t req,
  input  logic [63:0]        num,
  input  logic [32:0]        den,
  output pse_pkg::iter_stat_t stat,
  output logic [31:0]        result
);

  logic [34:0]                     rem;
  logic [63:0]                     acc;
  logic [32:0]                     dvs;
  pse_pkg::iter_op_t               op;
  logic [pse_pkg::ITER_CNT_W-1:0]  cnt;
  logic                            busy;
  logic                            done;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  // one digit of root or quotient per cycle
  always_comb begin
    if (op == pse_pkg::OP_SQRT) begin
      rem_sh = {rem[32:0], acc[63:62]};
      trial  = {1'b0, result, 2'b01};
    end else begin
      rem_sh = {rem[33:0], acc[63]};
      trial  = {2'b00, dvs};
    end
    ge = (rem_sh >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= pse_pkg::ITER_CNT_W'(pse_pkg::ITER_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pse_pkg::ITER_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op     <= req.op;
      dvs    <= den;
      result <= '0;
      if (req.op == pse_pkg::OP_SQRT) begin
        rem <= '0;
        acc <= num;
      end else begin
        rem <= {3'b000, num[63:32]};
        acc <= {num[31:0], 32'd0};
      end
    end else if (busy) begin
      rem    <= ge ? (rem_sh - trial) : rem_sh;
      result <= {result[30:0], ge};
      acc    <= (op == pse_pkg::OP_SQRT) ? {acc[61:0], 2'b00} : {acc[62:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: tb/sv/polyline_strip_extruder_tb.sv
// Testbench for the polyline strip extruder: directed and random paths checked against a predictor.
`timescale 1ns / 1ps

// One vertex as seen on the output port.
typedef struct packed {
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vz;
  logic [16:0]        u;
  logic               sd;
  logic               drop;
  logic               lastv;
} vertex_t;

// Queue of expected vertices; each accepted vertex is checked against the oldest one.
class vertex_scoreboard;
  vertex_t pending_verts[$];
  int      err_count;

  function void note_vertex(vertex_t v);
    pending_verts.insert(pending_verts.size(), v);
  endfunction

  function void check_vertex(vertex_t got);
    vertex_t exp_v;
    if (pending_verts.size() == 0) begin
      $error("unexpected vertex x=%0d z=%0d", got.vx, got.vz);
      err_count++;
      return;
    end
    exp_v = pending_verts.pop_front();
    if (got.vx !== exp_v.vx) begin
      $error("vert_x exp %0d got %0d", exp_v.vx, got.vx); err_count++;
    end
    if (got.vy !== exp_v.vy) begin
      $error("vert_y exp %0d got %0d", exp_v.vy, got.vy); err_count++;
    end
    if (got.vz !== exp_v.vz) begin
      $error("vert_z exp %0d got %0d", exp_v.vz, got.vz); err_count++;
    end
    if (got.u !== exp_v.u) begin
      $error("u_coord exp %0d got %0d", exp_v.u, got.u); err_count++;
    end
    if (got.sd !== exp_v.sd) begin
      $error("side exp %0d got %0d", exp_v.sd, got.sd); err_count++;
    end
    if (got.drop !== exp_v.drop) begin
      $error("dropped_points exp %0d got %0d", exp_v.drop, got.drop); err_count++;
    end
    if (got.lastv !== exp_v.lastv) begin
      $error("last_vertex exp %0d got %0d", exp_v.lastv, got.lastv); err_count++;
    end
  endfunction
endclass

module polyline_strip_extruder_tb;

  localparam int DEPTH = pse_pkg::MAX_POINTS_DEF;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] vert_x, vert_y, vert_z;
  logic [16:0] u_coord;
  logic side, dropped_points, last_vertex;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = pse_pkg::REG_STRIP_WIDTH;
  logic [31:0] cfg_data = '0;

  polyline_strip_extruder u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .u_coord(u_coord),
    .side(side), .dropped_points(dropped_points), .last_vertex(last_vertex),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  vertex_scoreboard sb = new();

  // predictor state
  logic signed [63:0] path_x[DEPTH];
  logic signed [63:0] path_y[DEPTH];
  logic [31:0]        path_arc[DEPTH];
  int                 path_len;
  logic [31:0]        path_total;
  logic               path_overflow;
  logic [30:0]        width_reg;
  logic [31:0]        height_reg;

  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Store one point and, on the last mark, queue every vertex of the path.
  function automatic void predict_point(logic signed [31:0] x, logic signed [31:0] y,
                                        logic lst);
    logic [63:0] a, b, sqa, sqb, l, ox, oz, u, w;
    logic [31:0] seg, arc;
    logic signed [63:0] dx, dy, offx, offz, sx, sz;
    int ia, ib;
    vertex_t v;
    if (path_len < DEPTH) begin
      arc = 0;
      if (path_len > 0) begin
        a = abs64(64'(x) - path_x[path_len-1]);
        b = abs64(64'(y) - path_y[path_len-1]);
        sqa = a * a;
        sqb = b * b;
        seg = (sqa > ~64'd0 - sqb) ? 32'hFFFFFFFF : 32'(int_sqrt(sqa + sqb));
        arc = path_arc[path_len-1];
        arc = (arc > 32'hFFFFFFFF - seg) ? 32'hFFFFFFFF : arc + seg;
      end
      path_x[path_len] = x;
      path_y[path_len] = y;
      path_arc[path_len] = arc;
      path_total = arc;
      path_len++;
    end else begin
      path_overflow = 1'b1;
    end
    if (!lst) return;
    w = 64'(width_reg);
    if (path_len >= 2) begin
      for (int i = 0; i < path_len; i++) begin
        ia = (i == 0) ? 0 : i - 1;
        ib = (i == path_len - 1) ? i : i + 1;
        dx = path_x[ib] - path_x[ia];
        dy = path_y[ib] - path_y[ia];
        a = abs64(dx);
        b = abs64(dy);
        if (a * a > ~64'd0 - b * b) begin
          a >>= 1;
          b >>= 1;
        end
        l = int_sqrt(a * a + b * b);
        ox = 0;
        oz = 0;
        u = 0;
        if (l != 0) begin
          ox = (b * w + l) / (2 * l);
          oz = (a * w + l) / (2 * l);
        end
        offx = (dy > 0) ? -$signed(ox) : $signed(ox);
        offz = (dx < 0) ? -$signed(oz) : $signed(oz);
        if (path_total != 0) u = ({32'd0, path_arc[i]} << 16) / path_total;
        for (int s = 0; s < 2; s++) begin
          sx = s ? -offx : offx;
          sz = s ? -offz : offz;
          v.vx = clamp32(path_x[i] + sx);
          v.vy = height_reg;
          v.vz = clamp32(path_y[i] + sz);
          v.u = u[16:0];
          v.sd = s[0];
          v.drop = path_overflow;
          v.lastv = (i == path_len - 1 && s == 1);
          sb.note_vertex(v);
        end
      end
    end
    path_len = 0;
    path_total = 0;
    path_overflow = 1'b0;
  endfunction

  // receiver: random stalls, check each accepted vertex
  always @(posedge clk) begin
    vertex_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.vx = vert_x; got.vy = vert_y; got.vz = vert_z; got.u = u_coord;
        got.sd = side; got.drop = dropped_points; got.lastv = last_vertex;
        sb.check_vertex(got);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("polyline_strip_extruder_tb: errors");
      $finish;
    end
  end

  // valid stays high into the next request unless the sender idles
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    last_point <= lst;
    do @(posedge clk); while (!in_ready);
    predict_point(x, y, lst);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_verts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pse_pkg::REG_STRIP_WIDTH) width_reg = val[30:0];
    else height_reg = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  // random path: mostly short, some overflowing, some degenerate
  task automatic random_path(ref int items);
    int n, kind;
    logic signed [31:0] x, y;
    kind = $urandom_range(19);
    n = (kind == 0) ? $urandom_range(33, 36) : (kind < 3 ? 1 : $urandom_range(2, 6));
    x = rand_coord();
    y = rand_coord();
    for (int k = 0; k < n; k++) begin
      if (kind == 3) begin
        // repeated point: zero tangents and zero length
      end else if ($urandom_range(3) == 0) begin
        x = rand_coord(); y = rand_coord();
      end else begin
        x = x + 32'($signed($urandom_range(400000)) - 200000);
        y = y + 32'($signed($urandom_range(400000)) - 200000);
      end
      send_point(x, y, k == n - 1);
      items++;
    end
  endtask

  initial begin
    int items;
    path_len = 0; path_total = 0; path_overflow = 0;
    width_reg = pse_pkg::STRIP_WIDTH_RESET;
    height_reg = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, extremes of coordinates, straight and degenerate paths
    send_point(0, 0, 0);
    send_point(32'sh10000, 0, 0);
    send_point(32'sh10000, 32'sh10000, 1);
    send_point(5, 5, 1);                          // single point: nothing out
    send_point(32'sh7FFFFFFF, 32'sh80000000, 0);  // huge segment
    send_point(32'sh80000000, 32'sh7FFFFFFF, 1);
    send_point(7, 9, 0);                          // zero tangent and zero length
    send_point(7, 9, 1);
    send_point(-100, 300, 0);
    send_point(200, -400, 0);
    send_point(-300, -500, 1);
    wait_drained();
    write_reg(pse_pkg::REG_STRIP_WIDTH, 32'h7FFFFFFF);
    write_reg(pse_pkg::REG_SURFACE_HEIGHT, 32'h80000000);
    send_point(32'sh7FFF0000, 0, 0);
    send_point(32'sh7FFF0000, 32'sh00010000, 1);
    // overflow path: 34 points, last two dropped
    for (int k = 0; k < 34; k++) send_point(k * 1000, -k * 700, k == 33);
    wait_drained();
    write_reg(pse_pkg::REG_STRIP_WIDTH, 0);
    write_reg(pse_pkg::REG_SURFACE_HEIGHT, 32'h7FFFFFFF);
    send_point(1, 2, 0);
    send_point(3, -4, 1);
    wait_drained();

    // random phases with varying idle patterns and settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1 ? 56 : 0);
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1 ? 17 : 0);
      write_reg(pse_pkg::REG_STRIP_WIDTH, $urandom());
      write_reg(pse_pkg::REG_SURFACE_HEIGHT, $urandom());
      items = 0;
      while (items < 65) random_path(items);
      wait_drained();
    end

    if (sb.err_count == 0)
      $display("polyline_strip_extruder_tb: clean");
    else
      $display("polyline_strip_extruder_tb: errors");
    $finish;
  end
endmodule
